// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while reset is released
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked while reset is released
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/pkdmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pkdmc_pkg
// types and codes of the pair keyed direct mapped cache
// ----------------------------------------------------------------------------
package pkdmc_pkg;

    localparam int KEY_W  = 32;
    localparam int AXIS_W = 32;
    localparam int ID_W   = 16;
    localparam int SLOT_W = 8;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam int IN_DATA_W  = 2 * KEY_W + SLOT_W + 4 * AXIS_W + 2 * ID_W;
    localparam int OUT_DATA_W = SLOT_W + 4 * AXIS_W + 2 * ID_W;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_HIT      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RESERVED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNAVAIL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd3;

    localparam logic [KEY_W-1:0]  FRAME_RESET = 32'd2;
    localparam logic [AXIS_W-1:0] SIGN_BIT    = 32'h8000_0000;

    typedef struct packed {
        logic [KEY_W-1:0] stamp;
        logic [KEY_W-1:0] tag_second;
        logic [KEY_W-1:0] tag_first;
    } t_tag_entry;

    typedef struct packed {
        logic [ID_W-1:0]   second_id;
        logic [ID_W-1:0]   first_id;
        logic [AXIS_W-1:0] axis_w;
        logic [AXIS_W-1:0] axis_z;
        logic [AXIS_W-1:0] axis_y;
        logic [AXIS_W-1:0] axis_x;
    } t_pay_entry;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key_first;
        logic [KEY_W-1:0]  key_second;
        logic [SLOT_W-1:0] slot8;
        t_pay_entry        pay;
    } t_req;

    typedef struct packed {
        logic tag_we;
        logic pay_we;
    } t_wr_ctl;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_out;
        t_pay_entry        pay;
    } t_result;

endpackage

// ----- rtl/pkdmc_resolve.sv -----
// ----------------------------------------------------------------------------
// pkdmc_resolve
// hit, swap, reservation and update decision for one request against its slot
// ----------------------------------------------------------------------------
module pkdmc_resolve (
    input  pkdmc_pkg::t_req       i_req,
    input  pkdmc_pkg::t_tag_entry i_tag,
    input  pkdmc_pkg::t_pay_entry i_pay,
    input  logic [31:0]           i_frame,
    input  logic                  i_enable,
    output pkdmc_pkg::t_wr_ctl    o_ctl,
    output pkdmc_pkg::t_tag_entry o_tag,
    output pkdmc_pkg::t_pay_entry o_pay,
    output pkdmc_pkg::t_result    o_res
);

    logic                  hit_fwd;
    logic                  hit_rev;
    logic [31:0]           age;
    pkdmc_pkg::t_pay_entry swp;

    assign hit_fwd = (i_tag.tag_first == i_req.key_first) &&
                     (i_tag.tag_second == i_req.key_second);
    assign hit_rev = (i_tag.tag_first == i_req.key_second) &&
                     (i_tag.tag_second == i_req.key_first);
    assign age     = i_frame - i_tag.stamp;

    // reversed view of the slot: ids exchanged, axis negated
    always_comb begin
        swp           = i_pay;
        swp.first_id  = i_pay.second_id;
        swp.second_id = i_pay.first_id;
        swp.axis_x    = i_pay.axis_x ^ pkdmc_pkg::SIGN_BIT;
        swp.axis_y    = i_pay.axis_y ^ pkdmc_pkg::SIGN_BIT;
        swp.axis_z    = i_pay.axis_z ^ pkdmc_pkg::SIGN_BIT;
        swp.axis_w    = i_pay.axis_w ^ pkdmc_pkg::SIGN_BIT;
    end

    always_comb begin
        o_ctl        = '0;
        o_tag        = i_tag;
        o_pay        = i_pay;
        o_res        = '0;
        o_res.status = pkdmc_pkg::STAT_DONE;
        case (i_req.op)
            pkdmc_pkg::OP_LOOKUP: begin
                if (!i_enable) begin
                    o_res.status = pkdmc_pkg::STAT_UNAVAIL;
                end else begin
                    o_res.slot_out = i_req.slot8;
                    if (hit_fwd) begin
                        o_tag.stamp  = i_frame;
                        o_ctl.tag_we = 1'b1;
                        o_res.status = pkdmc_pkg::STAT_HIT;
                        o_res.pay    = i_pay;
                    end else if (hit_rev) begin
                        o_tag.stamp      = i_frame;
                        o_tag.tag_first  = i_tag.tag_second;
                        o_tag.tag_second = i_tag.tag_first;
                        o_pay            = swp;
                        o_ctl.tag_we     = 1'b1;
                        o_ctl.pay_we     = 1'b1;
                        o_res.status     = pkdmc_pkg::STAT_HIT;
                        o_res.pay        = swp;
                    end else if (age > 32'd1) begin
                        o_tag.stamp      = i_frame;
                        o_tag.tag_first  = i_req.key_first;
                        o_tag.tag_second = i_req.key_second;
                        o_ctl.tag_we     = 1'b1;
                        o_res.status     = pkdmc_pkg::STAT_RESERVED;
                    end else begin
                        o_res.status = pkdmc_pkg::STAT_UNAVAIL;
                    end
                end
            end
            pkdmc_pkg::OP_UPDATE: begin
                o_pay          = i_req.pay;
                o_ctl.pay_we   = 1'b1;
                o_res.slot_out = i_req.slot8;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/pair_keyed_direct_mapped_cache_core.sv -----
// ----------------------------------------------------------------------------
// pair_keyed_direct_mapped_cache_core
// direct mapped cache keyed by an unordered pair of handles, xor hashed
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request word: tuser is the opcode (lookup, update,
//   tick, no operation), tdata packs the keys, slot and payload
//   m_axis returns exactly one result word per request: tuser is the status
//   (hit, reserved, unavailable, done), tdata packs slot and payload
//   cfg port: i_cfg_we / i_cfg_wdata write the cache enable bit; the user
//   writes it only while the block is idle, which the block does not enforce
// timing
//   a request is taken in the idle state and resolved in the exec state: the
//   slot is read from the tag and payload memories at the accept edge and
//   written back, with the result loaded into the m_axis output register,
//   once that register is free; tready stays low until then, so a new
//   request is not taken before the last one is resolved
// reset
//   synchronous active-low reset clears control, sets the frame counter to
//   two and enables the cache, then a clearing pass zeroes ENTRIES slots one
//   per cycle with s_axis tready low
// stalls
//   the result sits in an output register; a new request is taken while it
//   waits, and the next one holds in the resolve stage until the slot frees
// ----------------------------------------------------------------------------
module pair_keyed_direct_mapped_cache_core #(
    parameter int ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // key_first, key_second, slot_index, axis_x, axis_y, axis_z, axis_w,
    // first_feature_id, second_feature_id
    input  logic [pkdmc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // opcode
    input  logic [pkdmc_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // slot_out, cached_axis_x, cached_axis_y, cached_axis_z, cached_axis_w,
    // cached_first_id, cached_second_id
    output logic [pkdmc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [pkdmc_pkg::STAT_W-1:0]       o_m_axis_tuser
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // slot memories, one read per request and at most one write-back
    pkdmc_pkg::t_tag_entry r_tag_mem [ENTRIES];
    pkdmc_pkg::t_pay_entry r_pay_mem [ENTRIES];
    pkdmc_pkg::t_tag_entry r_tag_rd;
    pkdmc_pkg::t_pay_entry r_pay_rd;

    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_addr;
    pkdmc_pkg::t_req      r_req;
    logic [31:0]          r_frame;
    logic                 r_enable;
    logic                 r_out_valid;
    pkdmc_pkg::t_result   r_out;

    pkdmc_pkg::t_req       in_req;
    logic [AW-1:0]         in_addr;
    logic [31:0]           lk_slot32;
    logic [31:0]           up_slot32;
    logic [AW-1:0]         lk_slot;
    logic [AW-1:0]         up_slot;
    logic                  in_acc;
    logic                  out_free;
    logic                  exec_go;

    pkdmc_pkg::t_wr_ctl    ctl;
    pkdmc_pkg::t_tag_entry wr_tag;
    pkdmc_pkg::t_pay_entry wr_pay;
    pkdmc_pkg::t_result    res;

    logic                  tag_we;
    logic                  pay_we;
    logic [AW-1:0]         wr_addr;
    pkdmc_pkg::t_tag_entry tag_wdata;
    pkdmc_pkg::t_pay_entry pay_wdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign exec_go         = (r_state == S_EXEC) && out_free;

    // unpack the request word
    always_comb begin
        in_req                = '0;
        in_req.op             = i_s_axis_tuser;
        in_req.key_first      = i_s_axis_tdata[31:0];
        in_req.key_second     = i_s_axis_tdata[63:32];
        in_req.pay.axis_x     = i_s_axis_tdata[103:72];
        in_req.pay.axis_y     = i_s_axis_tdata[135:104];
        in_req.pay.axis_z     = i_s_axis_tdata[167:136];
        in_req.pay.axis_w     = i_s_axis_tdata[199:168];
        in_req.pay.first_id   = i_s_axis_tdata[215:200];
        in_req.pay.second_id  = i_s_axis_tdata[231:216];

        // xor hash for lookups, given slot (masked) for updates
        lk_slot   = AW'(i_s_axis_tdata[31:0] ^ i_s_axis_tdata[63:32]);
        up_slot32 = {24'd0, i_s_axis_tdata[71:64]};
        up_slot   = up_slot32[AW-1:0];
        in_addr   = (i_s_axis_tuser == pkdmc_pkg::OP_UPDATE) ? up_slot : lk_slot;
        lk_slot32 = 32'(in_addr);
        in_req.slot8 = lk_slot32[7:0];
    end

    pkdmc_resolve u_resolve (
        .i_req    (r_req),
        .i_tag    (r_tag_rd),
        .i_pay    (r_pay_rd),
        .i_frame  (r_frame),
        .i_enable (r_enable),
        .o_ctl    (ctl),
        .o_tag    (wr_tag),
        .o_pay    (wr_pay),
        .o_res    (res)
    );

    // write port: clearing pass or write-back of the resolved slot
    always_comb begin
        if (r_state == S_CLEAR) begin
            tag_we    = 1'b1;
            pay_we    = 1'b1;
            wr_addr   = r_clr_addr;
            tag_wdata = '0;
            pay_wdata = '0;
        end else begin
            tag_we    = exec_go && ctl.tag_we;
            pay_we    = exec_go && ctl.pay_we;
            wr_addr   = r_addr;
            tag_wdata = wr_tag;
            pay_wdata = wr_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[wr_addr] <= tag_wdata;
        end
        if (pay_we) begin
            r_pay_mem[wr_addr] <= pay_wdata;
        end
        if (in_acc) begin
            r_tag_rd <= r_tag_mem[in_addr];
            r_pay_rd <= r_pay_mem[in_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_frame     <= pkdmc_pkg::FRAME_RESET;
            r_enable    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (exec_go && (r_req.op == pkdmc_pkg::OP_TICK)) begin
                r_frame <= r_frame + 32'd1;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= in_req;
            r_addr <= in_addr;
        end
        if (exec_go) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {r_out.pay.second_id, r_out.pay.first_id,
                              r_out.pay.axis_w, r_out.pay.axis_z,
                              r_out.pay.axis_y, r_out.pay.axis_x,
                              r_out.slot_out};

endmodule

// ----- rtl/pkdmc_checker.sv -----
// ----------------------------------------------------------------------------
// pkdmc_checker
// port-level checks of the pair keyed cache core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pkdmc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic                             i_cfg_wdata,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [pkdmc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [pkdmc_pkg::OP_W-1:0]       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [pkdmc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [pkdmc_pkg::STAT_W-1:0]     o_m_axis_tuser
);

    logic in_acc;
    logic no_hit;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign no_hit = o_m_axis_tvalid && (o_m_axis_tuser != pkdmc_pkg::STAT_HIT);

    // a stalled result word stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // clearing pass keeps the input closed right after reset
    `ASSERT_IMPLIES(a_clear_closed, i_clk, i_rst_n, $past(!i_rst_n), !o_s_axis_tready)

    // one request in flight at a time
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_acc, !o_s_axis_tready)

    // only a hit carries payload
    `ASSERT_IMPLIES(a_payload_zero, i_clk, i_rst_n, no_hit,
        o_m_axis_tdata[pkdmc_pkg::OUT_DATA_W-1:pkdmc_pkg::SLOT_W] == '0)

endmodule

bind pair_keyed_direct_mapped_cache_core pkdmc_checker u_pkdmc_checker (.*);

// ----- test/tb_pair_keyed_direct_mapped_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_keyed_direct_mapped_cache_core
// self-checking bench for the pair keyed direct mapped cache core: a
// predictor tracks tags, stamps, payloads and the frame counter and checks
// every result word, under bursty requests and a stalling result sink
// ----------------------------------------------------------------------------
module tb_pair_keyed_direct_mapped_cache_core;

    localparam int SLOTS      = 256;
    localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int SETTLE     = 10;     // cycles after the last result
    localparam int POOL       = 24;     // pairs reused by the random part

    // request word as it sits on s_axis tdata, key_first in the lowest bits
    typedef struct packed {
        pkdmc_pkg::t_pay_entry        pay;
        logic [pkdmc_pkg::SLOT_W-1:0] slot_index;
        logic [pkdmc_pkg::KEY_W-1:0]  key_second;
        logic [pkdmc_pkg::KEY_W-1:0]  key_first;
    } t_req_bus;

    // result word as it sits on m_axis tdata, slot_out in the lowest bits
    typedef struct packed {
        pkdmc_pkg::t_pay_entry        pay;
        logic [pkdmc_pkg::SLOT_W-1:0] slot_out;
    } t_res_bus;

    typedef struct packed {
        logic [pkdmc_pkg::OP_W-1:0] op;
        t_req_bus                   data;
    } t_cache_word;

    // ------------------------------------------------------------------------
    // predictor and store of expected result words
    // ------------------------------------------------------------------------
    class pair_cache_board;
        logic [pkdmc_pkg::KEY_W-1:0] tag_a [SLOTS];
        logic [pkdmc_pkg::KEY_W-1:0] tag_b [SLOTS];
        logic [pkdmc_pkg::KEY_W-1:0] stamp [SLOTS];
        pkdmc_pkg::t_pay_entry       pay   [SLOTS];
        logic [pkdmc_pkg::KEY_W-1:0] frame;
        bit                          enable;
        int                          failures;
        pkdmc_pkg::t_result          pending_results [$];

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tag_a[i] = '0;
                tag_b[i] = '0;
                stamp[i] = '0;
                pay[i]   = '0;
            end
            frame    = pkdmc_pkg::FRAME_RESET;
            enable   = 1'b1;
            failures = 0;
        endfunction

        function void note_request(t_cache_word w);
            pkdmc_pkg::t_result           r;
            pkdmc_pkg::t_pay_entry        p;
            logic [pkdmc_pkg::SLOT_W-1:0] s;
            logic [pkdmc_pkg::KEY_W-1:0]  t;
            r        = '0;
            r.status = pkdmc_pkg::STAT_DONE;
            case (w.op)
                pkdmc_pkg::OP_LOOKUP: begin
                    s = pkdmc_pkg::SLOT_W'((w.data.key_first ^ w.data.key_second) % SLOTS);
                    if (!enable) begin
                        r.status = pkdmc_pkg::STAT_UNAVAIL;
                    end else begin
                        r.slot_out = s;
                        if (tag_a[s] == w.data.key_first && tag_b[s] == w.data.key_second) begin
                            stamp[s] = frame;
                            r.status = pkdmc_pkg::STAT_HIT;
                            r.pay    = pay[s];
                        end else if (tag_a[s] == w.data.key_second &&
                                     tag_b[s] == w.data.key_first) begin
                            // reversed pair: swap tags and ids, negate the axis
                            t               = tag_a[s];
                            tag_a[s]        = tag_b[s];
                            tag_b[s]        = t;
                            p               = pay[s];
                            pay[s].axis_x   = p.axis_x ^ pkdmc_pkg::SIGN_BIT;
                            pay[s].axis_y   = p.axis_y ^ pkdmc_pkg::SIGN_BIT;
                            pay[s].axis_z   = p.axis_z ^ pkdmc_pkg::SIGN_BIT;
                            pay[s].axis_w   = p.axis_w ^ pkdmc_pkg::SIGN_BIT;
                            pay[s].first_id  = p.second_id;
                            pay[s].second_id = p.first_id;
                            stamp[s] = frame;
                            r.status = pkdmc_pkg::STAT_HIT;
                            r.pay    = pay[s];
                        end else if (pkdmc_pkg::KEY_W'(frame - stamp[s]) > 1) begin
                            stamp[s] = frame;
                            tag_a[s] = w.data.key_first;
                            tag_b[s] = w.data.key_second;
                            r.status = pkdmc_pkg::STAT_RESERVED;
                        end else begin
                            r.status = pkdmc_pkg::STAT_UNAVAIL;
                        end
                    end
                end
                pkdmc_pkg::OP_UPDATE: begin
                    s          = pkdmc_pkg::SLOT_W'(w.data.slot_index % SLOTS);
                    pay[s]     = w.data.pay;
                    r.slot_out = s;
                end
                pkdmc_pkg::OP_TICK: frame = frame + 1;
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [pkdmc_pkg::STAT_W-1:0] status, t_res_bus bus);
            pkdmc_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("result word with no request waiting: status %0d", status);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, status);
            compare_field("slot_out", want.slot_out, bus.slot_out);
            compare_field("cached_axis_x", want.pay.axis_x, bus.pay.axis_x);
            compare_field("cached_axis_y", want.pay.axis_y, bus.pay.axis_y);
            compare_field("cached_axis_z", want.pay.axis_z, bus.pay.axis_z);
            compare_field("cached_axis_w", want.pay.axis_w, bus.pay.axis_w);
            compare_field("cached_first_id", want.pay.first_id, bus.pay.first_id);
            compare_field("cached_second_id", want.pay.second_id, bus.pay.second_id);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut hookup
    // ------------------------------------------------------------------------
    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic                              i_cfg_wdata;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [pkdmc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata;
    logic [pkdmc_pkg::OP_W-1:0]        i_s_axis_tuser;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic [pkdmc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic [pkdmc_pkg::STAT_W-1:0]      o_m_axis_tuser;

    pair_keyed_direct_mapped_cache_core #(
        .ENTRIES (SLOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    pair_cache_board board = new();

    // sender burst state and the pair pool of the random part
    int                           burst_left = 0;
    logic [pkdmc_pkg::KEY_W-1:0]  pool_first  [POOL];
    logic [pkdmc_pkg::KEY_W-1:0]  pool_second [POOL];
    logic [pkdmc_pkg::SLOT_W-1:0] pool_slot   [POOL];
    int                           idle_cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // result sink: stalls on modes of random length, including full-rate runs
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        i_m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(4, 60);
            for (int i = 0; i < span; i++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_m_axis_tready = 1'b1;                    // no backpressure
                    1:       i_m_axis_tready = 1'($urandom_range(0, 1)); // coin flip
                    2:       i_m_axis_tready = ($urandom_range(0, 7) == 0);
                    3:       i_m_axis_tready = (i % 3 == 2);            // fixed cadence
                    default: i_m_axis_tready = (i >= span / 2);         // long hold
                endcase
            end
        end
    end

    // every accepted result word goes straight to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tuser, o_m_axis_tdata);
    end

    // watchdog: any word moving on either side counts as progress
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_pair_keyed_direct_mapped_cache_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------
    function automatic t_cache_word junk_word(logic [pkdmc_pkg::OP_W-1:0] op);
        t_cache_word w;
        w.op                 = op;
        w.data.key_first     = $urandom;
        w.data.key_second    = $urandom;
        w.data.slot_index    = pkdmc_pkg::SLOT_W'($urandom);
        w.data.pay.axis_x    = $urandom;
        w.data.pay.axis_y    = $urandom;
        w.data.pay.axis_z    = $urandom;
        w.data.pay.axis_w    = $urandom;
        w.data.pay.first_id  = pkdmc_pkg::ID_W'($urandom);
        w.data.pay.second_id = pkdmc_pkg::ID_W'($urandom);
        return w;
    endfunction

    function automatic t_cache_word lookup_word(logic [pkdmc_pkg::KEY_W-1:0] ka,
                                                logic [pkdmc_pkg::KEY_W-1:0] kb);
        t_cache_word w;
        w                 = junk_word(pkdmc_pkg::OP_LOOKUP);
        w.data.key_first  = ka;
        w.data.key_second = kb;
        return w;
    endfunction

    function automatic t_cache_word update_word(logic [pkdmc_pkg::SLOT_W-1:0] s,
                                                logic [pkdmc_pkg::AXIS_W-1:0] x,
                                                logic [pkdmc_pkg::AXIS_W-1:0] y,
                                                logic [pkdmc_pkg::AXIS_W-1:0] z,
                                                logic [pkdmc_pkg::AXIS_W-1:0] w4,
                                                logic [pkdmc_pkg::ID_W-1:0] f,
                                                logic [pkdmc_pkg::ID_W-1:0] g);
        t_cache_word w;
        w                    = junk_word(pkdmc_pkg::OP_UPDATE);
        w.data.slot_index    = s;
        w.data.pay.axis_x    = x;
        w.data.pay.axis_y    = y;
        w.data.pay.axis_z    = z;
        w.data.pay.axis_w    = w4;
        w.data.pay.first_id  = f;
        w.data.pay.second_id = g;
        return w;
    endfunction

    // a few hot slots with several pairs each, so pairs evict one another
    function automatic void refill_pool();
        logic [pkdmc_pkg::SLOT_W-1:0] hot [8];
        for (int i = 0; i < 8; i++)
            hot[i] = pkdmc_pkg::SLOT_W'($urandom);
        for (int i = 0; i < POOL; i++) begin
            pool_slot[i]   = hot[$urandom_range(0, 7)];
            pool_first[i]  = $urandom;
            pool_second[i] = {24'($urandom_range(0, 32'hFF_FFFF)),
                              pool_first[i][7:0] ^ pool_slot[i]};
        end
    endfunction

    // half the words are lookups of known pairs in either order, with updates to
    // their slots and ticks so stamps age out; the rest is random noise
    function automatic t_cache_word random_word();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, POOL - 1);
        if (sel < 50) begin
            if ($urandom_range(0, 1))
                return lookup_word(pool_second[k], pool_first[k]);
            return lookup_word(pool_first[k], pool_second[k]);
        end else if (sel < 60) begin
            return lookup_word($urandom, $urandom);
        end else if (sel < 80) begin
            random_word = junk_word(pkdmc_pkg::OP_UPDATE);
            if ($urandom_range(0, 9) < 7)
                random_word.data.slot_index = pool_slot[k];
            return random_word;
        end else if (sel < 93) begin
            return junk_word(pkdmc_pkg::OP_TICK);
        end
        return junk_word(pkdmc_pkg::OP_NOP);
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------
    task automatic send_word(t_cache_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = w.data;
        i_s_axis_tuser  = w.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(w);
        burst_left--;
    endtask

    // stop sending and wait until every result word has come back
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        burst_left      = 0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_cache_enable(bit value);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        board.enable = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_phase(int count);
        refill_pool();
        repeat (count) send_word(random_word());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = pkdmc_pkg::OP_NOP;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // the clearing pass holds tready low; configure only once it is over
        do @(posedge i_clk); while (!o_s_axis_tready);
        set_cache_enable(1'b1);

        // fresh store: zero tags, so the pair (0,0) hits slot 0
        send_word(lookup_word(32'h0, 32'h0));
        send_word(update_word(8'd0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                              16'hFFFF, 16'h0));
        send_word(lookup_word(32'h0, 32'h0));
        // slot 6: reserve, then a conflicting pair in the same frame is refused
        send_word(lookup_word(32'd5, 32'd3));
        send_word(lookup_word(32'd7, 32'd1));
        send_word(update_word(8'd6, 32'h3F80_0000, 32'hBF80_0000, 32'h0, 32'h8000_0000,
                              16'h1234, 16'hFFFF));
        // reversed pair swaps the slot, then the same order hits straight
        send_word(lookup_word(32'd3, 32'd5));
        send_word(lookup_word(32'd3, 32'd5));
        // one frame later the stamp is still too fresh, two frames later it is not
        send_word(junk_word(pkdmc_pkg::OP_TICK));
        send_word(lookup_word(32'd7, 32'd1));
        send_word(junk_word(pkdmc_pkg::OP_TICK));
        send_word(lookup_word(32'd7, 32'd1));
        // all-ones keys land in slot 0, all-ones against zero in slot 255
        send_word(lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(lookup_word(32'hFFFF_FFFF, 32'h0));
        send_word(update_word(8'hFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                              16'h0, 16'hFFFF));
        send_word(lookup_word(32'h0, 32'hFFFF_FFFF));
        send_word(junk_word(pkdmc_pkg::OP_NOP));
        send_word(junk_word(pkdmc_pkg::OP_TICK));

        // disabled cache: lookups refused with slot zero, other operations still work
        set_cache_enable(1'b0);
        send_word(lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(update_word(8'd9, 32'h1, 32'h2, 32'h3, 32'h4, 16'h5, 16'h6));
        send_word(junk_word(pkdmc_pkg::OP_TICK));
        send_word(junk_word(pkdmc_pkg::OP_NOP));

        set_cache_enable(1'b1);
        random_phase(160);
        set_cache_enable(1'b0);
        random_phase(40);
        set_cache_enable(1'b1);
        random_phase(160);
        set_cache_enable(1'b0);
        random_phase(40);
        set_cache_enable(1'b1);
        random_phase(100);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (board.failures == 0 && board.pending_results.size() == 0) begin
            $display("tb_pair_keyed_direct_mapped_cache_core: PASS");
        end else begin
            $display("tb_pair_keyed_direct_mapped_cache_core: FAIL");
        end
        $finish;
    end

endmodule
